@@ src/ntps_pkg.sv @@
// shared types, constants and tables of the nonlinear thermal plant step
`timescale 1ns / 1ps

package ntps_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_ITERS_DEF = 18;

  localparam int DW        = 32;
  localparam int CW        = 35;
  localparam int PW        = 64;
  localparam int AW        = 66;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int ATAN_LEN  = 24;
  localparam int RED_STEPS = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_INIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_BEF_INIT  = 3'd5;

  localparam logic signed [DW-1:0] GAIN_A_RST     = 32'sd52429;
  localparam logic signed [DW-1:0] GAIN_B_RST     = 32'sd13107;
  localparam logic signed [DW-1:0] GAIN_C_RST     = 32'sd19661;
  localparam logic signed [DW-1:0] GAIN_D_RST     = 32'sd6554;
  localparam logic signed [DW-1:0] Y_INIT_RST     = 32'sd1310720;
  localparam logic signed [DW-1:0] Y_BEF_INIT_RST = 32'sd1179648;

  // angles in q5.30
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 35'sh1_921F_B544;
  localparam logic signed [CW-1:0] PI_Q30      = 35'sh0_C90F_DAA2;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 35'sh0_6487_ED51;
  localparam logic signed [CW-1:0] KGAIN_Q30   = 35'sh0_26DD_3B6A;

  localparam logic signed [AW-1:0] Y_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [AW-1:0] Y_MIN = -66'sh0_8000_0000;
  localparam logic signed [PW-1:0] SQ_MAX = 64'sh7FFF_FFFF;

  localparam logic [31:0] ATAN_TBL [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
    32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128
  };

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_A,
    MUL_B,
    MUL_C,
    MUL_D
  } mul_op_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_SQ,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    logic             accept;
    logic             red_step;
    logic             wrap;
    logic             fold;
    logic             cord_step;
    logic [CNT_W-1:0] cord_idx;
    logic             sin_round;
    mul_op_e          mul_op;
    acc_op_e          acc_op;
    logic             finish;
  } ntps_cmd_t;

  function automatic logic signed [CW-1:0] atan_lookup(input logic [CNT_W-1:0] idx);
    logic signed [CW-1:0] res;
    res = '0;
    if (idx < CNT_W'(ATAN_LEN)) begin
      res = $signed({3'b000, ATAN_TBL[idx]});
    end
    return res;
  endfunction

endpackage

@@ src/ntps_if.sv @@
// item channels and configuration channel of the plant step
`timescale 1ns / 1ps

interface ntps_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ntps_pkg::DW-1:0]    u_sample;
  logic                              first_of_run;

  modport source (output valid, output u_sample, output first_of_run, input ready);
  modport sink (input valid, input u_sample, input first_of_run, output ready);
endinterface

interface ntps_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ntps_pkg::DW-1:0]    y_next;
  logic                              overflow;

  modport source (output valid, output y_next, output overflow, input ready);
  modport sink (input valid, input y_next, input overflow, output ready);
endinterface

interface ntps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ntps_pkg::CFG_IDX_W-1:0]    index;
  logic [ntps_pkg::DW-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/ntps_ctrl.sv @@
// sequencer of the plant step: reduction, cordic and multiply phases
`timescale 1ns / 1ps

module ntps_ctrl #(
  parameter int CORDIC_ITERS = ntps_pkg::CORDIC_ITERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ntps_pkg::ntps_cmd_t cmd_o
);

  localparam int CNT_W = ntps_pkg::CNT_W;
  localparam logic [2:0] MCNT_DONE = 3'd5;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_WRAP = 4'd2;
  localparam logic [3:0] S_FOLD = 4'd3;
  localparam logic [3:0] S_CORD = 4'd4;
  localparam logic [3:0] S_SIN  = 4'd5;
  localparam logic [3:0] S_MULD = 4'd6;
  localparam logic [3:0] S_ACCD = 4'd7;
  localparam logic [3:0] S_SAT  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [2:0]        mcnt_q, mcnt_d;
  ntps_pkg::mul_op_e mop_q;
  logic              out_valid_q, out_valid_d;
  ntps_pkg::ntps_cmd_t cmd;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mcnt_d      = mcnt_q;
    cmd         = '0;
    cmd.mul_op  = ntps_pkg::MUL_NONE;
    cmd.acc_op  = ntps_pkg::ACC_NONE;
    cmd.cord_idx = cnt_q;
    in_ready_o  = 1'b0;

    // products that do not need the sine run ahead of the sine product
    if (state_q != S_IDLE) begin
      case (mcnt_q)
        3'd0:    cmd.mul_op = ntps_pkg::MUL_SQ;
        3'd1:    cmd.mul_op = ntps_pkg::MUL_A;
        3'd2:    cmd.mul_op = ntps_pkg::MUL_B;
        3'd3:    cmd.mul_op = ntps_pkg::MUL_C;
        default: cmd.mul_op = ntps_pkg::MUL_NONE;
      endcase
      if (mcnt_q != MCNT_DONE) begin
        mcnt_d = mcnt_q + 3'd1;
      end
    end

    case (mop_q) inside
      ntps_pkg::MUL_SQ:                                     cmd.acc_op = ntps_pkg::ACC_SQ;
      ntps_pkg::MUL_A, ntps_pkg::MUL_C, ntps_pkg::MUL_D:   cmd.acc_op = ntps_pkg::ACC_ADD;
      ntps_pkg::MUL_B:                                      cmd.acc_op = ntps_pkg::ACC_SUB;
      default:                                              cmd.acc_op = ntps_pkg::ACC_NONE;
    endcase

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          cnt_d      = '0;
          mcnt_d     = '0;
          state_d    = S_RED;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        cnt_d        = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ntps_pkg::RED_STEPS - 1)) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap = 1'b1;
        state_d  = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        cnt_d    = '0;
        state_d  = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CORDIC_ITERS - 1)) begin
          state_d = S_SIN;
        end
      end
      S_SIN: begin
        cmd.sin_round = 1'b1;
        state_d       = S_MULD;
      end
      S_MULD: begin
        cmd.mul_op = ntps_pkg::MUL_D;
        state_d    = S_ACCD;
      end
      S_ACCD: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.finish = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mcnt_q      <= MCNT_DONE;
      mop_q       <= ntps_pkg::MUL_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mcnt_q      <= mcnt_d;
      mop_q       <= cmd.mul_op;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_muld_after_early_products: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULD) |-> (mcnt_q == MCNT_DONE))
    else $error("sine product issued while early products pending");

  a_accept_starts_reduction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RED))
    else $error("accepted item did not start reduction");

  a_result_from_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_SAT))
    else $error("result raised outside saturation step");

  a_sat_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SAT && out_valid_q && !out_ready_i) |=> (state_q == S_SAT))
    else $error("result overwritten before it was taken");

endmodule

@@ src/ntps_dp.sv @@
// datapath of the plant step: state, gains, angle reduction, cordic, multiplier
`timescale 1ns / 1ps

module ntps_dp #(
  parameter int FRAC_BITS = ntps_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ntps_pkg::ntps_cmd_t                 cmd_i,
  input  logic signed [ntps_pkg::DW-1:0]      u_sample_i,
  input  logic                                first_of_run_i,
  input  logic                                cfg_we_i,
  input  logic [ntps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ntps_pkg::DW-1:0]             cfg_data_i,
  output logic signed [ntps_pkg::DW-1:0]      y_next_o,
  output logic                                overflow_o
);

  localparam int DW = ntps_pkg::DW;
  localparam int CW = ntps_pkg::CW;
  localparam int PW = ntps_pkg::PW;
  localparam int AW = ntps_pkg::AW;
  localparam int SHIFT_UP = 30 - FRAC_BITS;
  localparam int MAG_W = 62 - FRAC_BITS;
  localparam int QW = MAG_W - 32;
  localparam int RECIP_EXP = 62;
  localparam int RECIP_SHIFT = RECIP_EXP - SHIFT_UP;

  localparam logic [MAG_W-1:0] TWO_PI_M = MAG_W'(ntps_pkg::TWO_PI_Q30);
  localparam logic [DW-1:0] RECIP =
    DW'((64'd1 << RECIP_EXP) / 64'(ntps_pkg::TWO_PI_Q30));
  localparam logic signed [CW-1:0] SIN_HALF = CW'(1) <<< (SHIFT_UP - 1);
  localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [DW-1:0] gain_a_q, gain_b_q, gain_c_q, gain_d_q;
  logic signed [DW-1:0] y_init_q, y_bef_init_q;
  logic signed [DW-1:0] y_now_q, y_before_q, u_before_q;

  logic signed [DW-1:0] u_q, sq_q, sin_q;
  logic                 neg_q;
  logic [DW-1:0]        mag_q;
  logic [QW-1:0]        quo_q;
  logic [MAG_W-1:0]     raw_q, rem_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [PW-1:0] p_q;
  logic signed [AW-1:0] acc_q;
  logic                 ovf_q;
  logic signed [DW-1:0] y_next_q;
  logic                 overflow_q;

  logic signed [DW-1:0] sarg;
  logic [DW-1:0]        mag;
  logic [PW-1:0]        rprod;
  logic [QW-1:0]        quo;
  logic [MAG_W-1:0]     raw, rem_fix;
  logic signed [CW-1:0] rem_lo, r0, r1, zf, dx, dy, atan_v;
  logic signed [DW-1:0] opa, opb;
  logic signed [PW-1:0] prod, rp;
  logic signed [AW-1:0] rp_ext;
  logic signed [DW-1:0] res;
  logic                 res_ovf;

  always_comb begin
    sarg = first_of_run_i ? u_sample_i : u_before_q;
    mag  = sarg[DW-1] ? DW'(-sarg) : sarg;

    // modulo 2*pi: reciprocal estimate is exact or one low, one correction
    rprod   = mag_q * RECIP;
    quo     = QW'(rprod >> RECIP_SHIFT);
    raw     = (MAG_W'(mag_q) << SHIFT_UP) - MAG_W'(quo_q) * TWO_PI_M;
    rem_fix = (raw_q >= TWO_PI_M) ? (raw_q - TWO_PI_M) : raw_q;

    rem_lo = $signed(rem_q[CW-1:0]);
    r0 = (neg_q && rem_q != '0) ? (ntps_pkg::TWO_PI_Q30 - rem_lo) : rem_lo;
    r1 = (r0 >= ntps_pkg::PI_Q30) ? (r0 - ntps_pkg::TWO_PI_Q30) : r0;

    if (z_q > ntps_pkg::HALF_PI_Q30) begin
      zf = ntps_pkg::PI_Q30 - z_q;
    end else if (z_q < -ntps_pkg::HALF_PI_Q30) begin
      zf = -ntps_pkg::PI_Q30 - z_q;
    end else begin
      zf = z_q;
    end

    dx     = y_q >>> cmd_i.cord_idx;
    dy     = x_q >>> cmd_i.cord_idx;
    atan_v = ntps_pkg::atan_lookup(cmd_i.cord_idx);

    case (cmd_i.mul_op)
      ntps_pkg::MUL_SQ: begin
        opa = y_before_q;
        opb = y_before_q;
      end
      ntps_pkg::MUL_A: begin
        opa = gain_a_q;
        opb = y_now_q;
      end
      ntps_pkg::MUL_B: begin
        opa = gain_b_q;
        opb = sq_q;
      end
      ntps_pkg::MUL_C: begin
        opa = gain_c_q;
        opb = u_q;
      end
      ntps_pkg::MUL_D: begin
        opa = gain_d_q;
        opb = sin_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    prod = opa * opb;

    rp     = p_q >>> FRAC_BITS;
    rp_ext = AW'(rp);

    if (acc_q > ntps_pkg::Y_MAX) begin
      res     = 32'sh7FFF_FFFF;
      res_ovf = 1'b1;
    end else if (acc_q < ntps_pkg::Y_MIN) begin
      res     = -32'sh8000_0000;
      res_ovf = 1'b1;
    end else begin
      res     = acc_q[DW-1:0];
      res_ovf = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_a_q     <= ntps_pkg::GAIN_A_RST;
      gain_b_q     <= ntps_pkg::GAIN_B_RST;
      gain_c_q     <= ntps_pkg::GAIN_C_RST;
      gain_d_q     <= ntps_pkg::GAIN_D_RST;
      y_init_q     <= ntps_pkg::Y_INIT_RST;
      y_bef_init_q <= ntps_pkg::Y_BEF_INIT_RST;
      y_now_q      <= '0;
      y_before_q   <= '0;
      u_before_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ntps_pkg::CFG_GAIN_A:     gain_a_q     <= $signed(cfg_data_i);
          ntps_pkg::CFG_GAIN_B:     gain_b_q     <= $signed(cfg_data_i);
          ntps_pkg::CFG_GAIN_C:     gain_c_q     <= $signed(cfg_data_i);
          ntps_pkg::CFG_GAIN_D:     gain_d_q     <= $signed(cfg_data_i);
          ntps_pkg::CFG_Y_INIT:     y_init_q     <= $signed(cfg_data_i);
          ntps_pkg::CFG_Y_BEF_INIT: y_bef_init_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.accept && first_of_run_i) begin
        y_now_q    <= y_init_q;
        y_before_q <= y_bef_init_q;
      end else if (cmd_i.finish) begin
        y_before_q <= y_now_q;
        y_now_q    <= res;
        u_before_q <= u_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      u_q   <= u_sample_i;
      neg_q <= sarg[DW-1];
      mag_q <= mag;
    end else if (cmd_i.red_step) begin
      quo_q <= quo;
      raw_q <= raw;
      rem_q <= rem_fix;
    end

    if (cmd_i.wrap) begin
      z_q <= r1;
    end else if (cmd_i.fold) begin
      z_q <= zf;
      x_q <= ntps_pkg::KGAIN_Q30;
      y_q <= '0;
    end else if (cmd_i.cord_step) begin
      if (!z_q[CW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
    end

    if (cmd_i.sin_round) begin
      sin_q <= DW'((y_q + SIN_HALF) >>> SHIFT_UP);
    end

    if (cmd_i.mul_op != ntps_pkg::MUL_NONE) begin
      p_q <= prod + P_HALF;
    end

    if (cmd_i.accept) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      case (cmd_i.acc_op)
        ntps_pkg::ACC_SQ: begin
          if (rp > ntps_pkg::SQ_MAX) begin
            sq_q  <= 32'sh7FFF_FFFF;
            ovf_q <= 1'b1;
          end else begin
            sq_q <= rp[DW-1:0];
          end
        end
        ntps_pkg::ACC_ADD: acc_q <= acc_q + rp_ext;
        ntps_pkg::ACC_SUB: acc_q <= acc_q - rp_ext;
        default: ;
      endcase
    end

    if (cmd_i.finish) begin
      y_next_q   <= res;
      overflow_q <= res_ovf | ovf_q;
    end
  end

  assign y_next_o   = y_next_q;
  assign overflow_o = overflow_q;

endmodule

@@ src/nonlinear_thermal_plant_step.sv @@
// top level of the nonlinear thermal plant step
`timescale 1ns / 1ps

// One item is one control sample u; the block answers with
// y_next = a*y_now - b*y_before^2 + c*u + d*sin(u_before) in signed fixed point with
// FRAC_BITS fraction bits, saturated to 32 bits with an overflow flag. An item with
// first_of_run set reloads y_now and y_before from the initial registers and takes
// its own u as the sine argument. Items are handled one at a time: the sine comes
// from the CORDIC iterations; before them the sine argument is reduced modulo 2*pi
// by a reciprocal multiply, a multiply-subtract and one correction, and the four
// products that do not need the sine share one 32x32 multiplier ahead of the sine
// product. A finished result waits in an output register while the next item is
// taken. Configuration writes are always ready and take effect at once; they belong
// in idle periods.
module nonlinear_thermal_plant_step #(
  parameter int FRAC_BITS    = ntps_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_ITERS = ntps_pkg::CORDIC_ITERS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntps_in_if.sink    in_i,
  ntps_out_if.source out_o,
  ntps_cfg_if.sink   cfg_i
);

  ntps_pkg::ntps_cmd_t cmd;
  logic                cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  ntps_ctrl #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  ntps_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .u_sample_i     (in_i.u_sample),
    .first_of_run_i (in_i.first_of_run),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .y_next_o       (out_o.y_next),
    .overflow_o     (out_o.overflow)
  );

endmodule

@@ tb/nonlinear_thermal_plant_step_test.sv @@
// self-checking testbench of the plant step: fixed-point predictor, random handshakes, config phases
`timescale 1ns / 1ps

module nonlinear_thermal_plant_step_test;

  localparam int     FRAC          = 16;
  localparam int     SINE_SHIFT    = 30 - FRAC;
  localparam int     CORDIC_STEPS  = 18;
  localparam int     SETTLE_CYCLES = 45;
  localparam int     HOLD_CYCLES   = 300;
  localparam longint SAT_HI        = 64'sd2147483647;
  localparam longint SAT_LO        = -64'sd2147483648;
  localparam longint ANG_TWO_PI    = 64'sd6746518852;
  localparam longint ANG_PI        = 64'sd3373259426;
  localparam longint ANG_HALF_PI   = 64'sd1686629713;
  localparam longint ANG_KGAIN     = 64'sd652032874;
  localparam longint ANG_ATAN [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam logic signed [31:0] Q16_PI      = 32'sd205887;
  localparam logic signed [31:0] Q16_HALF_PI = 32'sd102944;

  typedef struct {
    logic signed [31:0] y_next;
    logic               overflow;
  } plant_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } reg_write_t;

  class plant_step_tracker;
    longint     gain_a, gain_b, gain_c, gain_d, y_init, y_prev_init;
    longint     y_now, y_prev, u_prev;
    plant_out_t pending_outputs[$];
    int         errors;

    function new();
      gain_a      = 52429;
      gain_b      = 13107;
      gain_c      = 19661;
      gain_d      = 6554;
      y_init      = 1310720;
      y_prev_init = 1179648;
      y_now       = 0;
      y_prev      = 0;
      u_prev      = 0;
      errors      = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      longint v;
      v = longint'($signed(data));
      case (idx)
        ntps_pkg::CFG_GAIN_A:     gain_a = v;
        ntps_pkg::CFG_GAIN_B:     gain_b = v;
        ntps_pkg::CFG_GAIN_C:     gain_c = v;
        ntps_pkg::CFG_GAIN_D:     gain_d = v;
        ntps_pkg::CFG_Y_INIT:     y_init = v;
        ntps_pkg::CFG_Y_BEF_INIT: y_prev_init = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction

    function longint round_shift(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint sine_q16(longint arg);
      longint r, x, y, z, dx, dy;
      r = (arg * 64'sd16384) % ANG_TWO_PI;
      if (r < 0) r += ANG_TWO_PI;
      if (r >= ANG_PI) r -= ANG_TWO_PI;
      if (r > ANG_HALF_PI) begin
        r = ANG_PI - r;
      end else if (r < -ANG_HALF_PI) begin
        r = -ANG_PI - r;
      end
      x = ANG_KGAIN;
      y = 0;
      z = r;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ANG_ATAN[i];
        end else begin
          x += dx;
          y -= dy;
          z += ANG_ATAN[i];
        end
      end
      return round_shift(y, SINE_SHIFT);
    endfunction

    function void take_sample(logic signed [31:0] u_s, bit first);
      longint     u, arg, sq, acc;
      plant_out_t res;
      u = u_s;
      res.overflow = 1'b0;
      if (first) begin
        y_now  = y_init;
        y_prev = y_prev_init;
        arg    = u;
      end else begin
        arg = u_prev;
      end
      sq = round_shift(y_prev * y_prev, FRAC);
      if (sq > SAT_HI) begin
        sq = SAT_HI;
        res.overflow = 1'b1;
      end
      acc = round_shift(gain_a * y_now, FRAC) - round_shift(gain_b * sq, FRAC)
          + round_shift(gain_c * u, FRAC) + round_shift(gain_d * sine_q16(arg), FRAC);
      if (acc > SAT_HI) begin
        acc = SAT_HI;
        res.overflow = 1'b1;
      end else if (acc < SAT_LO) begin
        acc = SAT_LO;
        res.overflow = 1'b1;
      end
      y_prev = y_now;
      y_now  = acc;
      u_prev = u;
      res.y_next = acc[31:0];
      pending_outputs.push_back(res);
    endfunction

    function void check_output(logic signed [31:0] y, logic ovf);
      plant_out_t want;
      if (pending_outputs.size() == 0) begin
        $error("result with no item outstanding: y_next %0d, overflow %0b", y, ovf);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      if (y !== want.y_next) begin
        $error("y_next mismatch: expected %0d, actual %0d", want.y_next, y);
        errors++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", want.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ntps_in_if  in_if ();
  ntps_out_if out_if ();
  ntps_cfg_if cfg_if ();

  nonlinear_thermal_plant_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  plant_step_tracker tracker;
  reg_write_t        cfg_plan[$];
  int                send_gap_pct;
  int                recv_stall_pct;
  int                run_left;
  bit                hold_request;
  int                hold_left;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // output side: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.check_output(out_if.y_next, out_if.overflow);
    end
  end

  function automatic logic signed [31:0] pick_sample();
    int                 sel;
    logic signed [31:0] v;
    sel = $urandom_range(99);
    if (sel < 45) begin
      v = int'($urandom_range(0, 4194304)) - 2097152;
    end else if (sel < 70) begin
      v = $urandom;
    end else if (sel < 88) begin
      v = Q16_HALF_PI * (int'($urandom_range(0, 16)) - 8) + int'($urandom_range(0, 8)) - 4;
    end else if (sel < 94) begin
      v = 32'sh7FFF_FFFF - int'($urandom_range(0, 3));
    end else begin
      v = 32'sh8000_0000 + int'($urandom_range(0, 3));
    end
    return v;
  endfunction

  function automatic logic [31:0] pick_gain(bit wide);
    return wide ? $urandom : int'($urandom_range(0, 262144)) - 131072;
  endfunction

  function automatic logic [31:0] pick_level(bit wide);
    return wide ? $urandom : int'($urandom_range(0, 13107200)) - 6553600;
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic offer_sample(input logic signed [31:0] u, input bit first);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 45);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.u_sample     <= u;
    in_if.first_of_run <= first;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_sample(u, first);
    @(negedge clk_i);
  endtask

  // mostly runs that open with first_of_run, with stray restarts and missing starts
  task automatic send_random(input int count);
    bit first;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 40);
        first    = ($urandom_range(19) != 0);
      end else begin
        run_left--;
        first = ($urandom_range(49) == 0);
      end
      offer_sample(pick_sample(), first);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_registers();
    foreach (cfg_plan[k]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_plan[k].index;
      cfg_if.data  <= cfg_plan[k].data;
      do @(posedge clk_i); while (!cfg_if.ready);
      tracker.set_register(cfg_plan[k].index, cfg_plan[k].data);
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    cfg_plan.delete();
  endtask

  task automatic program_plant(input bit wide);
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_A, pick_gain(wide)});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_B, pick_gain(wide)});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_C, pick_gain(wide)});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_D, pick_gain(wide)});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_INIT, pick_level(wide)});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_BEF_INIT, pick_level(wide)});
    write_registers();
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.u_sample     = '0;
    in_if.first_of_run = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    tracker            = new();
    send_gap_pct       = 0;
    recv_stall_pct     = 0;
    run_left           = 0;
    hold_request       = 1'b0;
    hold_left          = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, zero state before any run, sine argument corners
    offer_sample(32'sd0, 1'b0);
    offer_sample(32'sh7FFF_FFFF, 1'b0);
    offer_sample(32'sh8000_0000, 1'b0);
    offer_sample(32'sh0001_0000, 1'b0);
    offer_sample(32'sh8000_0000, 1'b1);
    offer_sample(32'sh7FFF_FFFF, 1'b1);
    offer_sample(Q16_PI, 1'b1);
    offer_sample(-Q16_PI, 1'b0);
    offer_sample(Q16_HALF_PI, 1'b0);
    offer_sample(-Q16_HALF_PI, 1'b0);
    offer_sample(Q16_PI * 2, 1'b0);
    send_random(170);
    wait_drained();

    send_gap_pct = 61;
    program_plant(1'b0);
    send_random(200);
    wait_drained();

    // all registers at one extreme
    send_gap_pct   = 0;
    recv_stall_pct = 61;
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_A, 32'h7FFF_FFFF});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_B, 32'h8000_0000});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_C, 32'h7FFF_FFFF});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_D, 32'h8000_0000});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_INIT, 32'h7FFF_FFFF});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_BEF_INIT, 32'h8000_0000});
    write_registers();
    offer_sample(32'sh7FFF_FFFF, 1'b1);
    offer_sample(32'sh8000_0000, 1'b0);
    offer_sample(32'sd0, 1'b1);
    send_random(170);
    wait_drained();

    // clamped square with a tiny gain_b, writes to unused indexes
    send_gap_pct   = 14;
    recv_stall_pct = 14;
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_A, 32'h0});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_B, 32'h1});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_C, 32'h0});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_D, 32'h0});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_INIT, 32'h0});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_BEF_INIT, 32'h8000_0000});
    cfg_plan.push_back('{CFG_SPARE_LO, 32'hFFFF_FFFF});
    cfg_plan.push_back('{CFG_SPARE_HI, 32'h5555_AAAA});
    write_registers();
    offer_sample(32'sd0, 1'b1);
    offer_sample(32'sd0, 1'b0);
    wait_drained();
    cfg_plan.push_back('{ntps_pkg::CFG_Y_BEF_INIT, 32'h7FFF_FFFF});
    write_registers();
    offer_sample(32'sd65536, 1'b1);
    wait_drained();
    program_plant(1'b1);
    send_random(170);
    wait_drained();

    // the opposite extremes
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_A, 32'h8000_0000});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_B, 32'h7FFF_FFFF});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_C, 32'h8000_0000});
    cfg_plan.push_back('{ntps_pkg::CFG_GAIN_D, 32'h7FFF_FFFF});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_INIT, 32'h8000_0000});
    cfg_plan.push_back('{ntps_pkg::CFG_Y_BEF_INIT, 32'h7FFF_FFFF});
    cfg_plan.push_back('{CFG_SPARE_HI, 32'h0});
    write_registers();
    offer_sample(32'sh8000_0000, 1'b1);
    offer_sample(32'sh7FFF_FFFF, 1'b0);
    send_random(170);
    wait_drained();

    // long output hold-off while items keep coming, then a full drain mid-run
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    program_plant(1'b0);
    send_random(40);
    hold_request = 1'b1;
    send_random(30);
    wait_drained();
    send_random(130);
    wait_drained();

    recv_stall_pct = 61;
    program_plant(1'b0);
    send_random(170);
    wait_drained();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
